// File: hdl/hrp_pkg.sv
// types, constants and per-character step function for the http response parser
`default_nettype none

package hrp_pkg;

   localparam int LENGTH_BITS = 32;
   localparam int NAME_MAX    = 17;

   typedef enum logic [2:0] {
      PH_STATUS  = 3'd0,
      PH_HEADERS = 3'd1,
      PH_BODY    = 3'd2,
      PH_DONE    = 3'd3,
      PH_ERROR   = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      RC_MORE  = 2'd0,
      RC_DONE  = 2'd1,
      RC_ERROR = 2'd2
   } result_type;

   // status line steps: 0..6 prefix, 7 minor version, 8 version digits, 9 blanks
   localparam logic [3:0] ST_PREFIX_END = 4'd7;
   localparam logic [3:0] ST_MINOR      = 4'd7;
   localparam logic [3:0] ST_VERSION    = 4'd8;
   localparam logic [3:0] ST_BLANK      = 4'd9;
   localparam logic [3:0] ST_CODE       = 4'd10;
   localparam logic [3:0] ST_AFTER      = 4'd11;
   localparam logic [3:0] ST_FAIL       = 4'd12;

   localparam logic [1:0] DG_BLANK = 2'd0;
   localparam logic [1:0] DG_NUM   = 2'd1;
   localparam logic [1:0] DG_END   = 2'd2;

   localparam logic [2:0] NM_LEN = 3'b001;
   localparam logic [2:0] NM_ENC = 3'b010;
   localparam logic [2:0] NM_CON = 3'b100;
   localparam logic [2:0] NM_ALL = 3'b111;

   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_C     = 8'h63;

   localparam logic [9:0] CODE_MAX = 10'd999;
   localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

   localparam logic [8*NAME_MAX-1:0] LIT_PREFIX  = (8*NAME_MAX)'("HTTP/1.");
   localparam logic [8*NAME_MAX-1:0] LIT_LEN     = (8*NAME_MAX)'("content-length");
   localparam logic [8*NAME_MAX-1:0] LIT_ENC     = (8*NAME_MAX)'("transfer-encoding");
   localparam logic [8*NAME_MAX-1:0] LIT_CON     = (8*NAME_MAX)'("connection");
   localparam logic [8*NAME_MAX-1:0] LIT_CHUNKED = (8*NAME_MAX)'("chunked");
   localparam logic [8*NAME_MAX-1:0] LIT_CLOSE   = (8*NAME_MAX)'("close");

   localparam logic [4:0] LEN_PREFIX  = 5'd7;
   localparam logic [4:0] LEN_LEN     = 5'd14;
   localparam logic [4:0] LEN_ENC     = 5'd17;
   localparam logic [4:0] LEN_CON     = 5'd10;
   localparam logic [4:0] POS_LIMIT   = 5'd31;
   localparam logic [2:0] LEN_CHUNKED = 3'd7;
   localparam logic [2:0] LEN_CLOSE   = 3'd5;

   // per-line scan state plus the status line progress
   typedef struct packed {
      logic [3:0]             status_step;
      logic [9:0]             code_value;
      logic [4:0]             name_position;
      logic [2:0]             name_alive;
      logic                   in_value;
      logic [LENGTH_BITS-1:0] value_number;
      logic [1:0]             digit_phase;
      logic [2:0]             token_progress;
   } line_type;

   // result fields of one beat
   typedef struct packed {
      result_type result_code;
      phase_type  parse_phase;
      logic [9:0] resp_code;
      logic [31:0] body_length;
      logic       chunked_seen;
      logic       close_seen;
      logic       body_byte;
   } result_fields_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   // true when b equals the byte at pos of a right-aligned literal of length len
   function automatic logic lit_match(input logic [8*NAME_MAX-1:0] lit, input logic [4:0] len,
                                      input logic [4:0] pos, input logic [7:0] b);
      logic [8*NAME_MAX-1:0] sh;
      sh = '0;
      if (pos >= len) return 1'b0;
      sh = lit >> (8 * (int'(len) - int'(pos) - 1));
      return sh[7:0] == b;
   endfunction

   function automatic line_type line_clear(input line_type s);
      line_type n;
      n = s;
      n.name_position  = '0;
      n.name_alive     = NM_ALL;
      n.in_value       = 1'b0;
      n.value_number   = '0;
      n.digit_phase    = DG_BLANK;
      n.token_progress = '0;
      return n;
   endfunction

   function automatic logic [2:0] token_step(input logic [8*NAME_MAX-1:0] lit,
                                             input logic [2:0] len, input logic [2:0] prog,
                                             input logic [7:0] b);
      if (prog >= len) return prog;
      if (lit_match(lit, {2'b00, len}, {2'b00, prog}, b)) return 3'(prog + 3'd1);
      return (b == CH_C) ? 3'd1 : 3'd0;
   endfunction

   // one character of a status or header line
   function automatic line_type char_step(input logic in_status, input line_type s,
                                          input logic [7:0] b);
      line_type                 n;
      logic [7:0]               lb;
      logic [13:0]              cv;
      logic [LENGTH_BITS+3:0]   lv;
      logic [2:0]               keep;
      n    = s;
      lb   = b;
      keep = '0;
      cv   = 14'(s.code_value) * 14'd10 + 14'(b[3:0]);
      lv   = (LENGTH_BITS+4)'(s.value_number) * (LENGTH_BITS+4)'(10)
             + (LENGTH_BITS+4)'(b[3:0]);
      if (in_status) begin
         if (s.status_step < ST_PREFIX_END) begin
            n.status_step = lit_match(LIT_PREFIX, LEN_PREFIX, {1'b0, s.status_step}, b) ?
                            4'(s.status_step + 4'd1) : ST_FAIL;
         end else if (s.status_step == ST_MINOR) begin
            if (is_digit(b)) n.status_step = ST_VERSION;
            else if (!is_space(b)) n.status_step = ST_FAIL;
         end else if (s.status_step == ST_VERSION) begin
            if (is_space(b)) n.status_step = ST_BLANK;
            else if (!is_digit(b)) n.status_step = ST_FAIL;
         end else if (s.status_step == ST_BLANK) begin
            if (is_digit(b)) begin
               n.status_step = ST_CODE;
               n.code_value  = {6'd0, b[3:0]};
            end else if (!is_space(b)) begin
               n.status_step = ST_FAIL;
            end
         end else if (s.status_step == ST_CODE) begin
            if (is_digit(b)) n.code_value = (cv > 14'(CODE_MAX)) ? CODE_MAX : cv[9:0];
            else n.status_step = ST_AFTER;
         end
      end else if (!s.in_value) begin
         if (b == CH_COLON) begin
            if (s.name_alive[0] && s.name_position == LEN_LEN) keep = NM_LEN;
            if (s.name_alive[1] && s.name_position == LEN_ENC) keep = NM_ENC;
            if (s.name_alive[2] && s.name_position == LEN_CON) keep = NM_CON;
            n.name_alive = keep;
            n.in_value   = 1'b1;
         end else begin
            if (b >= 8'h41 && b <= 8'h5a) lb = 8'(b + 8'd32);
            if (!lit_match(LIT_LEN, LEN_LEN, s.name_position, lb)) n.name_alive[0] = 1'b0;
            if (!lit_match(LIT_ENC, LEN_ENC, s.name_position, lb)) n.name_alive[1] = 1'b0;
            if (!lit_match(LIT_CON, LEN_CON, s.name_position, lb)) n.name_alive[2] = 1'b0;
            if (s.name_position < POS_LIMIT) n.name_position = 5'(s.name_position + 5'd1);
         end
      end else begin
         case (s.name_alive)
            NM_LEN: begin
               if (s.digit_phase == DG_BLANK) begin
                  if (is_digit(b)) begin
                     n.digit_phase  = DG_NUM;
                     n.value_number = LENGTH_BITS'(b[3:0]);
                  end else if (!is_space(b)) begin
                     n.digit_phase = DG_END;
                  end
               end else if (s.digit_phase == DG_NUM) begin
                  if (is_digit(b))
                     n.value_number = (lv > (LENGTH_BITS+4)'(LEN_MAX)) ? LEN_MAX :
                                      lv[LENGTH_BITS-1:0];
                  else
                     n.digit_phase = DG_END;
               end
            end
            NM_ENC:  n.token_progress = token_step(LIT_CHUNKED, LEN_CHUNKED, s.token_progress, b);
            NM_CON:  n.token_progress = token_step(LIT_CLOSE, LEN_CLOSE, s.token_progress, b);
            default: n = s;
         endcase
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// File: hdl/http_response_header_parser_core.sv
// result: a result beat is registered and valid in the cycle after its request beat is accepted
// throughput: one request beat per cycle unless stalled, one result beat per request beat
// the result register is reloaded in the same cycle it is taken, so stalls cost nothing extra
// reset: synchronous active-high reset clears the parser and drops any pending result
// a restart beat clears all parse state and answers with the cleared state
// top level of the http response header parser
`default_nettype none

module http_response_header_parser_core import hrp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte[7:0]
   input  wire logic        req_tuser,   // operation: 0 data byte, 1 restart
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [47:0] rsp_tdata,   // parse_phase[2:0], resp_code[12:3],
                                         // body_length[44:13], chunked_seen[45],
                                         // close_seen[46], body_byte[47]
   output      logic [1:0]  rsp_tuser    // result_code[1:0]
);

   logic              req_fire;
   logic              rsp_valid_ff, rsp_valid_in;
   result_fields_type rsp_ff, rsp_in;

   // take a new beat whenever the result register is empty or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   hrp_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .beat      (req_fire),
      .restart   (req_tuser),
      .data_byte (req_tdata),
      .result    (rsp_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.result_code;
   assign rsp_tdata  = {rsp_ff.body_byte, rsp_ff.close_seen, rsp_ff.chunked_seen,
                        rsp_ff.body_length, rsp_ff.resp_code, rsp_ff.parse_phase};

   a_restart_result: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser |=> rsp_tvalid && rsp_tuser == RC_MORE &&
                                rsp_tdata[2:0] == PH_STATUS && !rsp_tdata[47])
      else $error("restart beat did not give a cleared result");

   a_body_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[47] |-> rsp_tdata[2:0] == PH_BODY || rsp_tdata[2:0] == PH_DONE)
      else $error("body byte flagged outside the body");

   a_code_matches_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == RC_DONE) == (rsp_tdata[2:0] == PH_DONE) &&
                     (rsp_tuser == RC_ERROR) == (rsp_tdata[2:0] == PH_ERROR))
      else $error("result code disagrees with phase");

endmodule

`default_nettype wire

// File: hdl/hrp_engine.sv
// parser state registers and the per-beat next-state logic
`default_nettype none

module hrp_engine import hrp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              beat,
   input  wire logic              restart,
   input  wire logic [7:0]        data_byte,
   output result_fields_type      result
);

   phase_type              phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic                   chunked_ff, chunked_in;
   logic                   close_ff, close_in;
   line_type               line_ff, line_in;
   logic [1:0]             class_ff, class_in;
   logic                   body;
   logic                   in_status;
   line_type               line_reset;

   always_comb begin
      line_reset             = line_clear('0);
      line_reset.status_step = '0;
      line_reset.code_value  = '0;
   end

   assign in_status = (phase_ff == PH_STATUS);

   always_comb begin
      phase_in   = phase_ff;
      len_in     = len_ff;
      count_in   = count_ff;
      chunked_in = chunked_ff;
      close_in   = close_ff;
      line_in    = line_ff;
      class_in   = class_ff;
      body       = 1'b0;
      if (restart) begin
         phase_in   = PH_STATUS;
         len_in     = '0;
         count_in   = '0;
         chunked_in = 1'b0;
         close_in   = 1'b0;
         line_in    = line_reset;
         class_in   = '0;
      end else begin
         case (phase_ff)
            PH_BODY: begin
               body     = 1'b1;
               count_in = LENGTH_BITS'(count_ff + 1'b1);
               if ({1'b0, count_ff} + 1'b1 >= {1'b0, len_ff}) phase_in = PH_DONE;
            end
            PH_STATUS, PH_HEADERS: begin
               if (data_byte == CH_LF) begin
                  // end of line: commit, held cr dropped
                  if (in_status) begin
                     phase_in = (line_ff.status_step == ST_CODE ||
                                 line_ff.status_step == ST_AFTER) ? PH_HEADERS : PH_ERROR;
                  end else if (!class_ff[0]) begin
                     phase_in = (len_ff != '0) ? PH_BODY : PH_DONE;
                  end else if (!line_ff.in_value) begin
                     phase_in = PH_ERROR;
                  end else if (line_ff.name_alive == NM_LEN) begin
                     len_in = line_ff.value_number;
                  end else if (line_ff.name_alive == NM_ENC) begin
                     if (line_ff.token_progress == LEN_CHUNKED) chunked_in = 1'b1;
                  end else if (line_ff.name_alive == NM_CON) begin
                     if (line_ff.token_progress == LEN_CLOSE) close_in = 1'b1;
                  end
                  line_in  = line_clear(line_ff);
                  class_in = '0;
               end else begin
                  // a held cr that is not followed by lf counts as whitespace
                  if (class_ff[1]) begin
                     line_in  = char_step(in_status, line_in, CH_CR);
                     class_in = 2'b01;
                  end
                  if (data_byte == CH_CR) begin
                     class_in[1] = 1'b1;
                  end else begin
                     line_in  = char_step(in_status, line_in, data_byte);
                     class_in = 2'b01;
                  end
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   always_comb begin
      case (phase_in)
         PH_DONE:  result.result_code = RC_DONE;
         PH_ERROR: result.result_code = RC_ERROR;
         default:  result.result_code = RC_MORE;
      endcase
      result.parse_phase  = phase_in;
      result.resp_code    = line_in.code_value;
      result.body_length  = 32'(len_in);
      result.chunked_seen = chunked_in;
      result.close_seen   = close_in;
      result.body_byte    = body;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_STATUS;
         len_ff     <= '0;
         count_ff   <= '0;
         chunked_ff <= 1'b0;
         close_ff   <= 1'b0;
         line_ff    <= line_reset;
         class_ff   <= '0;
      end else if (beat) begin
         phase_ff   <= phase_in;
         len_ff     <= len_in;
         count_ff   <= count_in;
         chunked_ff <= chunked_in;
         close_ff   <= close_in;
         line_ff    <= line_in;
         class_ff   <= class_in;
      end
   end

   a_body_below_length: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> count_ff < len_ff)
      else $error("body count reached length while still in body");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      beat && !restart && phase_ff == PH_DONE |=> phase_ff == PH_DONE)
      else $error("complete state left without restart");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      beat && restart |=> phase_ff == PH_STATUS && line_ff.name_alive == NM_ALL &&
                          class_ff == 2'b00)
      else $error("restart did not clear the parser");

endmodule

`default_nettype wire

// File: bench/http_response_header_parser_core_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the http response header parser core

module http_response_header_parser_core_tb;
   import hrp_pkg::*;

   localparam int HALF_PERIOD     = 4;
   localparam int RANDOM_ITEMS    = 250;
   localparam int IDLE_LIMIT      = 2000;
   localparam int HOLD_OFF_CYCLES = 240;
   localparam int BURST_MAX       = 24;

   // line terminations offered to the parser
   localparam int EOL_LF     = 0;
   localparam int EOL_CRLF   = 1;
   localparam int EOL_CRCRLF = 2;

   // receiver ready patterns
   localparam int RX_ALWAYS = 0;
   localparam int RX_MOSTLY = 1;
   localparam int RX_HALF   = 2;
   localparam int RX_TOGGLE = 3;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = 1'b0;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   http_response_header_parser_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // data_byte[7:0]
      .req_tuser  (req_tuser),   // operation: 0 data byte, 1 restart
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // parse_phase, resp_code, body_length, chunked_seen,
                                 // close_seen, body_byte
      .rsp_tuser  (rsp_tuser)    // result_code
   );

   always #(HALF_PERIOD) clock = ~clock;

   // expected result beats, oldest first
   result_fields_type expected_beats[$];
   result_fields_type oldest_beat;

   int error_count   = 0;
   int results_seen  = 0;
   int items_sent    = 0;
   int burst_left    = 0;
   int gap_limit     = 0;
   int hold_cycles   = 0;
   int idle_cycles   = 0;
   int ready_pattern = RX_ALWAYS;
   int pattern_left  = 0;

   // parser state as predicted from the accepted beats
   phase_type   ps_phase;
   logic [9:0]  ps_code;
   logic [31:0] ps_length;
   logic        ps_chunked;
   logic        ps_close;
   logic [31:0] ps_body;
   logic [3:0]  ps_status;
   logic [4:0]  ps_npos;
   logic [2:0]  ps_alive;
   logic        ps_in_value;
   logic [31:0] ps_number;
   logic [1:0]  ps_digits;
   logic [2:0]  ps_token;
   logic        ps_line_has;
   logic        ps_cr_held;

   function automatic bit blank_char(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   function automatic bit digit_char(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   // header names in the order of the name_alive bits
   function automatic string header_name(input int k);
      case (k)
         0:       return "content-length";
         1:       return "transfer-encoding";
         default: return "connection";
      endcase
   endfunction

   // substring search that restarts on a 'c'
   function automatic logic [2:0] token_advance(input string tok, input logic [2:0] got,
                                                input logic [7:0] c);
      if (got >= tok.len()) return got;
      if (tok[got] == c) return got + 3'd1;
      return (c == CH_C) ? 3'd1 : 3'd0;
   endfunction

   task automatic clear_line_state();
      ps_npos     = '0;
      ps_alive    = NM_ALL;
      ps_in_value = 1'b0;
      ps_number   = '0;
      ps_digits   = DG_BLANK;
      ps_token    = '0;
      ps_line_has = 1'b0;
      ps_cr_held  = 1'b0;
   endtask

   task automatic clear_parser();
      ps_phase   = PH_STATUS;
      ps_code    = '0;
      ps_length  = '0;
      ps_chunked = 1'b0;
      ps_close   = 1'b0;
      ps_body    = '0;
      ps_status  = '0;
      clear_line_state();
   endtask

   task automatic status_char_step(input logic [7:0] c);
      string prefix;
      int    grown;
      prefix = "HTTP/1.";
      grown  = int'(ps_code) * 10 + int'(c) - 48;
      if (ps_status < ST_PREFIX_END) begin
         if (c == prefix[ps_status]) ps_status = ps_status + 4'd1;
         else ps_status = ST_FAIL;
      end else if (ps_status == ST_MINOR) begin
         if (digit_char(c)) ps_status = ST_VERSION;
         else if (!blank_char(c)) ps_status = ST_FAIL;
      end else if (ps_status == ST_VERSION) begin
         if (blank_char(c)) ps_status = ST_BLANK;
         else if (!digit_char(c)) ps_status = ST_FAIL;
      end else if (ps_status == ST_BLANK) begin
         if (digit_char(c)) begin
            ps_status = ST_CODE;
            ps_code   = 10'(c - 8'h30);
         end else if (!blank_char(c)) begin
            ps_status = ST_FAIL;
         end
      end else if (ps_status == ST_CODE) begin
         if (!digit_char(c)) ps_status = ST_AFTER;
         else if (grown > 999) ps_code = CODE_MAX;
         else ps_code = 10'(grown);
      end
   endtask

   task automatic header_char_step(input logic [7:0] c);
      logic [2:0]        keep;
      logic [7:0]        low;
      longint unsigned   wide;
      string             nm;
      if (!ps_in_value) begin
         if (c == CH_COLON) begin
            // only a name matched to its full length survives the colon
            keep = '0;
            for (int k = 0; k < 3; k++) begin
               nm = header_name(k);
               if (ps_alive[k] && ps_npos == nm.len()) keep = 3'(1 << k);
            end
            ps_alive    = keep;
            ps_in_value = 1'b1;
         end else begin
            low = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
            for (int k = 0; k < 3; k++) begin
               nm = header_name(k);
               if (ps_npos >= nm.len() || nm[ps_npos] != low) ps_alive[k] = 1'b0;
            end
            if (ps_npos < POS_LIMIT) ps_npos = ps_npos + 5'd1;
         end
      end else begin
         case (ps_alive)
            NM_LEN: begin
               if (ps_digits == DG_BLANK) begin
                  if (digit_char(c)) begin
                     ps_digits = DG_NUM;
                     ps_number = 32'(c - 8'h30);
                  end else if (!blank_char(c)) begin
                     ps_digits = DG_END;
                  end
               end else if (ps_digits == DG_NUM) begin
                  if (digit_char(c)) begin
                     wide      = 64'(ps_number) * 64'd10 + 64'(c) - 64'd48;
                     ps_number = (wide > 64'hffff_ffff) ? '1 : 32'(wide);
                  end else begin
                     ps_digits = DG_END;
                  end
               end
            end
            NM_ENC:  ps_token = token_advance("chunked", ps_token, c);
            NM_CON:  ps_token = token_advance("close", ps_token, c);
            default: ;
         endcase
      end
   endtask

   task automatic line_char_step(input logic [7:0] c);
      if (ps_phase == PH_STATUS) status_char_step(c);
      else header_char_step(c);
   endtask

   task automatic end_line();
      if (ps_phase == PH_STATUS) begin
         if (ps_status == ST_CODE || ps_status == ST_AFTER) ps_phase = PH_HEADERS;
         else ps_phase = PH_ERROR;
      end else if (!ps_line_has) begin
         // blank line: body only when a nonzero length was committed
         if (ps_length != 0) ps_phase = PH_BODY;
         else ps_phase = PH_DONE;
      end else if (!ps_in_value) begin
         ps_phase = PH_ERROR;
      end else if (ps_alive == NM_LEN) begin
         ps_length = ps_number;
      end else if (ps_alive == NM_ENC) begin
         if (ps_token == LEN_CHUNKED) ps_chunked = 1'b1;
      end else if (ps_alive == NM_CON) begin
         if (ps_token == LEN_CLOSE) ps_close = 1'b1;
      end
      clear_line_state();
   endtask

   // advance the predicted parser by one accepted beat and give its result
   task automatic predict_beat(input logic restart, input logic [7:0] c,
                               output result_fields_type r);
      logic body;
      body = 1'b0;
      if (restart) begin
         clear_parser();
      end else if (ps_phase == PH_BODY) begin
         body    = 1'b1;
         ps_body = ps_body + 32'd1;
         if (ps_body >= ps_length) ps_phase = PH_DONE;
      end else if (ps_phase == PH_STATUS || ps_phase == PH_HEADERS) begin
         if (c == CH_LF) begin
            end_line();
         end else begin
            // a held cr that is not followed by lf counts as whitespace
            if (ps_cr_held) begin
               line_char_step(CH_CR);
               ps_line_has = 1'b1;
               ps_cr_held  = 1'b0;
            end
            if (c == CH_CR) begin
               ps_cr_held = 1'b1;
            end else begin
               line_char_step(c);
               ps_line_has = 1'b1;
            end
         end
      end
      if (ps_phase == PH_DONE) r.result_code = RC_DONE;
      else if (ps_phase == PH_ERROR) r.result_code = RC_ERROR;
      else r.result_code = RC_MORE;
      r.parse_phase  = ps_phase;
      r.resp_code    = ps_code;
      r.body_length  = ps_length;
      r.chunked_seen = ps_chunked;
      r.close_seen   = ps_close;
      r.body_byte    = body;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("%0t ns: %s at result %0d: got 0x%0h, expected 0x%0h",
               $time, what, results_seen, got, want);
   endtask

   // result checker: every accepted beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_beats.size() == 0) begin
            report_mismatch("result beat with nothing pending", 32'(rsp_tuser), 32'd0);
         end else begin
            oldest_beat = expected_beats.pop_front();
            if (rsp_tuser !== oldest_beat.result_code)
               report_mismatch("result_code", 32'(rsp_tuser), 32'(oldest_beat.result_code));
            if (rsp_tdata[2:0] !== oldest_beat.parse_phase)
               report_mismatch("parse_phase", 32'(rsp_tdata[2:0]),
                               32'(oldest_beat.parse_phase));
            if (rsp_tdata[12:3] !== oldest_beat.resp_code)
               report_mismatch("resp_code", 32'(rsp_tdata[12:3]),
                               32'(oldest_beat.resp_code));
            if (rsp_tdata[44:13] !== oldest_beat.body_length)
               report_mismatch("body_length", rsp_tdata[44:13], oldest_beat.body_length);
            if (rsp_tdata[45] !== oldest_beat.chunked_seen)
               report_mismatch("chunked_seen", 32'(rsp_tdata[45]), 32'(oldest_beat.chunked_seen));
            if (rsp_tdata[46] !== oldest_beat.close_seen)
               report_mismatch("close_seen", 32'(rsp_tdata[46]), 32'(oldest_beat.close_seen));
            if (rsp_tdata[47] !== oldest_beat.body_byte)
               report_mismatch("body_byte", 32'(rsp_tdata[47]), 32'(oldest_beat.body_byte));
         end
      end
   end

   // receiver: random ready patterns, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles--;
      end else begin
         if (pattern_left == 0) begin
            ready_pattern = $urandom_range(RX_ALWAYS, RX_TOGGLE);
            pattern_left  = $urandom_range(16, 96);
         end
         pattern_left--;
         case (ready_pattern)
            RX_ALWAYS: rsp_tready <= 1'b1;
            RX_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
            RX_HALF:   rsp_tready <= 1'($urandom_range(0, 1));
            default:   rsp_tready <= ~rsp_tready;
         endcase
      end
   end

   // watchdog: too long without any beat on either side ends the run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // offer one beat, in bursts with random gaps, and record its expected result
   task automatic send_beat(input logic restart, input logic [7:0] c);
      result_fields_type want;
      if (burst_left == 0) begin
         if (gap_limit > 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, gap_limit)) @(negedge clock);
         end
         burst_left = $urandom_range(1, BURST_MAX);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= restart;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      predict_beat(restart, c, want);
      expected_beats.push_back(want);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_beat(1'b0, text[i]);
   endtask

   task automatic send_line_end(input int style);
      if (style == EOL_CRCRLF) send_beat(1'b0, CH_CR);
      if (style != EOL_LF) send_beat(1'b0, CH_CR);
      send_beat(1'b0, CH_LF);
   endtask

   // sender pause: no valid until every expected result has come back
   task automatic settle_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (expected_beats.size() != 0);
   endtask

   function automatic string decimal(input int unsigned v);
      return $sformatf("%0d", v);
   endfunction

   function automatic string mixed_case(input string s);
      string t;
      t = s;
      for (int i = 0; i < t.len(); i++)
         if (t[i] >= 8'h61 && t[i] <= 8'h7a && $urandom_range(0, 1) == 1) t[i] = t[i] - 8'd32;
      return t;
   endfunction

   function automatic string blanks(input int n);
      string t;
      t = "";
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 3) == 0) t = {t, "\t"};
         else t = {t, " "};
      end
      return t;
   endfunction

   function automatic string length_value();
      string num;
      case ($urandom_range(0, 9))
         0:       num = "";
         1:       num = {decimal($urandom_range(1, 99999)), decimal($urandom_range(10000, 99999)),
                         "00"};
         2:       num = ($urandom_range(0, 1) == 1) ? "4294967295" : "4294967296";
         3:       num = {"0", decimal($urandom_range(0, 9))};
         default: num = decimal($urandom_range(0, 12));
      endcase
      // signs end the number with value zero
      if ($urandom_range(0, 7) == 0) begin
         if ($urandom_range(0, 1) == 1) num = {"+", num};
         else num = {"-", num};
      end
      if ($urandom_range(0, 5) == 0) num = {num, " x"};
      return {blanks($urandom_range(0, 2)), num};
   endfunction

   function automatic string encoding_value();
      case ($urandom_range(0, 5))
         0:       return "chunked";
         1:       return " gzip, chunked";
         2:       return "cchunked";
         3:       return "chunke";
         4:       return "Chunked";
         default: return "identity";
      endcase
   endfunction

   function automatic string connection_value();
      case ($urandom_range(0, 4))
         0:       return "close";
         1:       return " keep-alive";
         2:       return " cclose";
         3:       return "Close";
         default: return "clos";
      endcase
   endfunction

   function automatic string near_miss_name();
      case ($urandom_range(0, 4))
         0:       return "content-lengt";
         1:       return "content-lengthh";
         2:       return "transfer_encoding";
         3:       return "connection ";
         default: return "x-content-length";
      endcase
   endfunction

   task automatic send_status_line();
      string text;
      int    idx;
      text = {"HTTP/1.", decimal($urandom_range(0, 11)), blanks($urandom_range(1, 2))};
      if ($urandom_range(0, 3) == 0) text = {text, decimal($urandom_range(0, 99999))};
      else text = {text, decimal($urandom_range(100, 599))};
      if ($urandom_range(0, 2) == 0) text = {text, " OK"};
      // occasionally break one character of the line
      if ($urandom_range(0, 7) == 0) begin
         idx       = $urandom_range(0, text.len() - 1);
         text[idx] = 8'($urandom_range(33, 126));
      end
      send_text(text);
      send_line_end($urandom_range(EOL_LF, EOL_CRCRLF));
   endtask

   task automatic send_header_line();
      logic [7:0] c;
      case ($urandom_range(0, 11))
         0, 1, 2, 3: send_text({mixed_case("content-length"), ":", length_value()});
         4, 5:       send_text({mixed_case("transfer-encoding"), ":", encoding_value()});
         6, 7:       send_text({mixed_case("connection"), ":", connection_value()});
         8:          send_text({mixed_case(near_miss_name()), ": 5 close chunked"});
         10: begin
            // a line without a colon is an error, so keep it rare
            if ($urandom_range(0, 2) == 0) send_text("no colon here");
            else send_text("Server: tiny");
         end
         11:         send_text(":7");
         default: begin
            send_text({mixed_case("x-trace"), ":"});
            repeat ($urandom_range(0, 8)) begin
               c = 8'($urandom_range(0, 255));
               if (c == CH_LF) c = 8'h00;
               send_beat(1'b0, c);
            end
         end
      endcase
      send_line_end($urandom_range(EOL_LF, EOL_CRCRLF));
   endtask

   // response with random, sometimes malformed content, body sized by the parsed length up to 40 bytes
   task automatic send_response();
      int count;
      send_status_line();
      repeat ($urandom_range(0, 4))
         if (ps_phase == PH_HEADERS) send_header_line();
      if (ps_phase == PH_HEADERS) send_line_end($urandom_range(EOL_LF, EOL_CRCRLF));
      count = 0;
      while (ps_phase == PH_BODY && count < 40) begin
         send_beat(1'b0, 8'($urandom_range(0, 255)));
         count++;
      end
      repeat ($urandom_range(0, 2)) send_beat(1'b0, 8'($urandom_range(0, 255)));
   endtask

   // unstructured bytes with many line breaks and the odd restart
   task automatic send_noise();
      int pick;
      repeat ($urandom_range(5, 25)) begin
         pick = $urandom_range(0, 15);
         if (pick == 0) send_beat(1'b1, 8'($urandom_range(0, 255)));
         else if (pick <= 3) send_beat(1'b0, CH_LF);
         else if (pick == 4) send_beat(1'b0, CH_CR);
         else send_beat(1'b0, 8'($urandom_range(0, 255)));
      end
   endtask

   // zero and all-ones bytes on a status line, then a byte ignored after the error
   task automatic test_byte_extremes();
      send_beat(1'b1, 8'hff);
      send_beat(1'b0, 8'h00);
      send_beat(1'b0, 8'hff);
      send_beat(1'b0, CH_LF);
      send_beat(1'b0, 8'h7f);
   endtask

   // saturating status code, held cr as whitespace, blank line with no length
   task automatic test_status_line();
      send_beat(1'b1, 8'h00);
      send_text("HTTP/1.1\t 12345");
      send_line_end(EOL_CRCRLF);
      send_line_end(EOL_LF);
      send_beat(1'b0, 8'h80);
   endtask

   // signed length, saturating length, both tokens, then a body that never ends
   task automatic test_header_fields();
      send_beat(1'b1, 8'h01);
      send_text("HTTP/1.0 204");
      send_line_end(EOL_LF);
      send_text("Content-LENGTH:-7");
      send_line_end(EOL_LF);
      send_text("content-length: 4294967296");
      send_line_end(EOL_CRLF);
      send_text("Transfer-Encoding: gzip,cchunked");
      send_line_end(EOL_CRLF);
      send_text("CONNECTION:x");
      send_beat(1'b0, CH_CR);
      send_text("close");
      send_line_end(EOL_LF);
      send_line_end(EOL_CRLF);
      send_beat(1'b0, CH_LF);
      send_beat(1'b0, CH_CR);
      send_beat(1'b0, 8'hff);
   endtask

   // short body to completion, missing colon, bad version, chunked without length
   task automatic test_body_and_errors();
      send_beat(1'b1, 8'h00);
      send_text("HTTP/1.1 200");
      send_line_end(EOL_LF);
      send_text("content-length: 2");
      send_line_end(EOL_LF);
      send_line_end(EOL_LF);
      send_text("ok!");
      send_beat(1'b1, 8'h00);
      send_text("HTTP/1.1 200");
      send_line_end(EOL_LF);
      send_text("no colon");
      send_line_end(EOL_LF);
      send_beat(1'b1, 8'h00);
      send_text("HTTP/2 200");
      send_line_end(EOL_LF);
      send_beat(1'b1, 8'h00);
      send_text("HTTP/1.1 200");
      send_line_end(EOL_LF);
      send_text("transfer-encoding: chunked");
      send_line_end(EOL_LF);
      send_line_end(EOL_LF);
   endtask

   // receiver holds off while the sender keeps offering, so the input stalls
   task automatic test_receiver_hold_off();
      settle_results();
      gap_limit   = 0;
      hold_cycles = HOLD_OFF_CYCLES;
      send_beat(1'b1, 8'h00);
      send_text("HTTP/1.1 200");
      send_line_end(EOL_CRLF);
      send_text("Content-Length: 5");
      send_line_end(EOL_CRLF);
      send_line_end(EOL_CRLF);
      send_text("hello");
      settle_results();
   endtask

   task automatic test_random_traffic();
      int first;
      first = items_sent;
      while (items_sent - first < RANDOM_ITEMS) begin
         // some responses go out with no gaps at all
         gap_limit = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         send_beat(1'b1, 8'($urandom_range(0, 255)));
         if ($urandom_range(0, 9) == 0) send_noise();
         else send_response();
      end
   endtask

   initial begin
      clear_parser();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset     <= 1'b0;
      gap_limit = 4;
      test_byte_extremes();
      test_status_line();
      test_header_fields();
      test_body_and_errors();
      test_receiver_hold_off();
      test_random_traffic();
      settle_results();
      repeat (4) @(negedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: http_response_header_parser_core.f
hdl/hrp_pkg.sv
hdl/hrp_engine.sv
hdl/http_response_header_parser_core.sv
bench/http_response_header_parser_core_tb.sv
